// File: rtl/sfdt_pkg.sv
// Shared constants and types for the stereo feedback delay with tail.
package sfdt_pkg;

    // Configuration register widths and reset values.
    localparam int DLY_W     = 19;
    localparam int GAIN_W    = 16;
    localparam int TAIL_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam int DELAY_RST = 24000;
    localparam int GAIN_RST  = 16384;
    localparam int TAIL_RST  = 480000;

    // Q1.15 rounding of the feedback product.
    localparam int Q_SHIFT    = 15;
    localparam int ROUND_HALF = 16384;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY = 2'd0,
        REG_GAIN  = 2'd1,
        REG_TAIL  = 2'd2
    } cfg_reg_t;

    // Per-word control that travels beside the lane data.
    typedef struct packed {
        logic vld;    // stage holds a word
        logic act;    // voice was on for this word
        logic we;     // word reads the delay line and writes it back
        logic rd_ok;  // read address was written at least once
        logic feed;   // dry sample goes into the loop
    } lane_ctl_t;

endpackage

// File: rtl/sfdt_rem.sv
// Reciprocal-multiply remainder unit that folds the delay length into the delay memory depth.
module sfdt_rem #(
    parameter int DELAY_DEPTH = 524288
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [sfdt_pkg::DLY_W-1:0]           delay_in,
    output logic                                 busy,
    output logic [$clog2(DELAY_DEPTH)-1:0]       off
);
    import sfdt_pkg::*;

    localparam int PW = $clog2(DELAY_DEPTH);
    localparam int SH = DLY_W + PW;          // reciprocal scale
    localparam int CW = DLY_W + 1;           // reciprocal width
    localparam int MW = DLY_W + CW;          // estimate product width
    localparam int DW = DLY_W + PW + 1;      // quotient times depth width
    localparam longint RECIP = (longint'(1) << SH) / longint'(DELAY_DEPTH);
    localparam logic [CW-1:0] RECIP_C = CW'(RECIP);
    localparam logic [PW:0]   DEPTH_C = (PW+1)'(DELAY_DEPTH);
    localparam int OFF_RST = DELAY_RST % DELAY_DEPTH;

    logic [DLY_W-1:0] x_reg;
    logic [MW-1:0]    est_reg;
    logic             est_vld_reg;
    logic [PW:0]      r_reg;
    logic             r_vld_reg;
    logic [PW-1:0]    off_reg;

    logic [MW-1:0]    est_next;
    logic [DLY_W-1:0] quo;
    logic [DW-1:0]    qd;
    logic [DW-1:0]    diff;
    logic [PW:0]      fix;

    // The quotient estimate is the true quotient or one less, so the first
    // remainder lies below twice the depth and one compare and subtract ends it.
    always_comb
    begin
        est_next = delay_in * RECIP_C;
        quo      = DLY_W'(est_reg >> SH);
        qd       = quo * DEPTH_C;
        diff     = DW'(x_reg) - qd;
        fix      = (r_reg >= DEPTH_C) ? (r_reg - DEPTH_C) : r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            est_reg     <= '0;
            est_vld_reg <= 1'b0;
            r_reg       <= '0;
            r_vld_reg   <= 1'b0;
            off_reg     <= PW'(OFF_RST);
        end
        else
        begin
            est_vld_reg <= start;
            r_vld_reg   <= est_vld_reg;
            if (start)
            begin
                x_reg   <= delay_in;
                est_reg <= est_next;
            end
            if (est_vld_reg)
            begin
                r_reg <= diff[PW:0];
            end
            if (r_vld_reg)
            begin
                off_reg <= fix[PW-1:0];
            end
        end
    end

    assign busy = est_vld_reg || r_vld_reg;
    assign off  = off_reg;

endmodule

// File: rtl/sfdt_lane.sv
// One audio channel: delay memory, write forwarding, feedback multiply and saturation.
module sfdt_lane #(
    parameter int DELAY_DEPTH = 524288,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic signed [SAMPLE_BITS-1:0]        dry,
    input  logic [$clog2(DELAY_DEPTH)-1:0]       s0_rd_addr,
    input  sfdt_pkg::lane_ctl_t                  s1_ctl,
    input  logic [$clog2(DELAY_DEPTH)-1:0]       s1_rd_addr,
    input  sfdt_pkg::lane_ctl_t                  s2_ctl,
    input  logic [$clog2(DELAY_DEPTH)-1:0]       s2_wr_addr,
    input  logic [sfdt_pkg::GAIN_W-1:0]          gain,
    output logic signed [SAMPLE_BITS-1:0]        sample
);
    import sfdt_pkg::*;

    localparam int PW = $clog2(DELAY_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int MW = SB + GAIN_W + 1;   // product width
    localparam int RW = MW - Q_SHIFT;      // rounded product width
    localparam int XW = SB + 3;            // width ahead of saturation
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    function automatic logic signed [SB-1:0] sat(input logic signed [XW-1:0] v);
        logic [XW-SB:0] top;
        begin
            top = v[XW-1:SB-1];
            if ((top == '0) || (top == '1))
            begin
                sat = v[SB-1:0];
            end
            else
            begin
                sat = v[XW-1] ? SMIN : SMAX;
            end
        end
    endfunction

    logic signed [SB-1:0] mem [DELAY_DEPTH];

    logic signed [SB-1:0] rd_q_reg;
    logic signed [SB-1:0] dry_s1_reg;
    logic signed [SB-1:0] dry_s2_reg;
    logic signed [SB-1:0] g_s2_reg;
    logic signed [MW-1:0] prod_s2_reg;
    logic                 w_hit_reg;
    logic [PW-1:0]        w_addr_reg;
    logic signed [SB-1:0] w_data_reg;

    logic signed [SB-1:0] g_s1;
    logic signed [MW-1:0] prod_s1;
    logic signed [MW-1:0] q_s2;
    logic signed [RW-1:0] rnd_s2;
    logic signed [SB-1:0] feed_s2;
    logic signed [XW-1:0] wsum_s2;
    logic signed [SB-1:0] wsat_s2;
    logic signed [XW-1:0] osum_s2;

    // Stage 2: round the product, add fed dry, saturate; output is dry plus delayed.
    always_comb
    begin
        q_s2    = prod_s2_reg + MW'(ROUND_HALF);
        rnd_s2  = q_s2[MW-1:Q_SHIFT];
        feed_s2 = s2_ctl.feed ? dry_s2_reg : '0;
        wsum_s2 = XW'(feed_s2) + XW'(rnd_s2);
        wsat_s2 = sat(wsum_s2);
        osum_s2 = XW'(dry_s2_reg) + XW'(g_s2_reg);
    end

    // Stage 1: the youngest pending write to the read address wins.
    always_comb
    begin
        priority if (s2_ctl.vld && s2_ctl.we && (s2_wr_addr == s1_rd_addr))
        begin
            g_s1 = wsat_s2;
        end
        else if (w_hit_reg && (w_addr_reg == s1_rd_addr))
        begin
            g_s1 = w_data_reg;
        end
        else if (s1_ctl.rd_ok)
        begin
            g_s1 = rd_q_reg;
        end
        else
        begin
            g_s1 = '0;
        end
        if (!s1_ctl.we)
        begin
            g_s1 = '0;
        end
        prod_s1 = g_s1 * $signed({1'b0, gain});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_q_reg <= mem[s0_rd_addr];
            if (s2_ctl.vld && s2_ctl.we)
            begin
                mem[s2_wr_addr] <= wsat_s2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dry_s1_reg  <= dry;
            dry_s2_reg  <= dry_s1_reg;
            g_s2_reg    <= g_s1;
            prod_s2_reg <= prod_s1;
            w_addr_reg  <= s2_wr_addr;
            w_data_reg  <= wsat_s2;
        end
    end

    // Marks whether a write landed at the same edge as the last read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_hit_reg <= s2_ctl.vld && s2_ctl.we;
        end
    end

    assign sample = sat(osum_s2);

endmodule

// File: rtl/stereo_feedback_delay_with_tail.sv
// Top level of the stereo feedback delay with tail: control, lanes and output register.
//
// Usage. Each input word is one stereo audio frame (dry_left, dry_right, feed_enable,
// dry_active, note_start) on a valid/stall channel; each frame gives exactly one
// output word (out_left, out_right, voice_active) on a valid/stall channel.
// Registers delay_samples (index 0), feedback_gain (1) and tail_length (2) are
// written through the cfg_valid/cfg_ready port; the user must write them only while
// no frame is in flight, as the block itself does not enforce it. An accepted frame
// moves through the s1 and s2 pipeline registers into the output register.
// Throughput: one frame per cycle while nothing stalls, set by the single read and
// single write port of each lane's delay memory; feedback through delays of one or
// two frames is forwarded. Writing delay_samples starts a remainder step against
// the memory depth that holds off input and further register writes while it runs.
// Reset clears the write pointer, tail counter and voice state and loads the register
// defaults; the memories are not swept: a wrapped flag and the write pointer tell
// which entries were ever written, and unwritten ones read as zero.
// When the receiver stalls, the output register holds its word; the pipeline moves
// if the last stage is empty; input stalls only when it is blocked or u_rem is busy.
module stereo_feedback_delay_with_tail #(
    parameter int DELAY_DEPTH = 524288,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         dry_left,
    input  logic signed [SAMPLE_BITS-1:0]         dry_right,
    input  logic                                  feed_enable,
    input  logic                                  dry_active,
    input  logic                                  note_start,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         out_left,
    output logic signed [SAMPLE_BITS-1:0]         out_right,
    output logic                                  voice_active,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfdt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfdt_pkg::DLY_W-1:0]            cfg_data
);
    import sfdt_pkg::*;

    localparam int PW = $clog2(DELAY_DEPTH);
    localparam logic [PW-1:0] WP_LAST = PW'(DELAY_DEPTH - 1);

    // Configuration registers.
    logic [DLY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [TAIL_W-1:0] tail_len_reg;

    // Voice and pointer state.
    logic [PW-1:0]     wp_reg;
    logic              wrapped_reg;
    logic [TAIL_W-1:0] tail_reg;
    logic              voice_on_reg;
    logic              prev_reg;

    // Pipeline control.
    lane_ctl_t         s1_ctl_reg;
    lane_ctl_t         s2_ctl_reg;
    logic [PW-1:0]     s1_rd_reg;
    logic [PW-1:0]     s1_wr_reg;
    logic [PW-1:0]     s2_wr_reg;

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          voice_reg;

    logic              cfg_wr;
    logic              busy;
    logic [PW-1:0]     off;
    logic              adv;
    logic              in_acc;

    logic              prev0;
    logic              von0;
    logic [TAIL_W-1:0] tail0;
    logic [TAIL_W-1:0] tail1;
    logic              we0;
    logic [PW:0]       rd_wrap;
    logic [PW-1:0]     rd0;
    logic              rd_ok0;
    logic [PW-1:0]     wp_next;
    logic [TAIL_W-1:0] tail_next;
    logic              voice_next;
    lane_ctl_t         s0_ctl;

    logic signed [SAMPLE_BITS-1:0] lane_left;
    logic signed [SAMPLE_BITS-1:0] lane_right;

    assign cfg_ready = !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // The whole pipeline shifts unless a finished word in the last stage cannot leave.
    assign adv      = !(s2_ctl_reg.vld && out_valid_reg && out_stall);
    assign in_stall = busy || !adv;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DLY_W'(DELAY_RST);
            gain_reg     <= GAIN_W'(GAIN_RST);
            tail_len_reg <= TAIL_W'(TAIL_RST);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_DELAY: delay_reg    <= cfg_data;
                REG_GAIN:  gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_TAIL:  tail_len_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    sfdt_rem #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr && (cfg_index == REG_DELAY)),
        .delay_in (cfg_data),
        .busy     (busy),
        .off      (off)
    );

    // Frame control at acceptance. A note start switches the voice on, clears the
    // tail and counts the previous dry activity as set, so a frame that starts a
    // note without dry activity loads the tail at once.
    always_comb
    begin
        prev0 = note_start || prev_reg;
        von0  = note_start || voice_on_reg;
        tail0 = note_start ? '0 : tail_reg;
        tail1 = (prev0 && !dry_active) ? tail_len_reg : tail0;

        // A zero delay bypasses the memories and holds the pointer.
        we0 = von0 && (delay_reg != '0);

        rd_wrap = {1'b0, wp_reg} + (PW+1)'(DELAY_DEPTH) - {1'b0, off};
        rd0     = (wp_reg >= off) ? (wp_reg - off) : rd_wrap[PW-1:0];
        // Until the pointer first wraps, only addresses below it were written.
        rd_ok0  = wrapped_reg || (rd0 < wp_reg);
        wp_next = (wp_reg == WP_LAST) ? '0 : (wp_reg + 1'b1);

        // The tail counts down on frames without dry activity; the voice goes
        // off when it reaches zero or if it is already zero.
        if (!von0)
        begin
            tail_next  = tail0;
            voice_next = 1'b0;
        end
        else if (dry_active)
        begin
            tail_next  = tail1;
            voice_next = 1'b1;
        end
        else if (tail1 != '0)
        begin
            tail_next  = tail1 - 1'b1;
            voice_next = (tail1 != TAIL_W'(1));
        end
        else
        begin
            tail_next  = '0;
            voice_next = 1'b0;
        end

        s0_ctl.vld   = in_acc;
        s0_ctl.act   = von0;
        s0_ctl.we    = we0;
        s0_ctl.rd_ok = rd_ok0;
        s0_ctl.feed  = feed_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            tail_reg     <= '0;
            voice_on_reg <= 1'b0;
            prev_reg     <= 1'b0;
        end
        else if (in_acc)
        begin
            prev_reg     <= dry_active;
            voice_on_reg <= voice_next;
            tail_reg     <= tail_next;
            if (we0)
            begin
                wp_reg <= wp_next;
                if (wp_reg == WP_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= s0_ctl;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rd_reg <= rd0;
            s1_wr_reg <= wp_reg;
            s2_wr_reg <= s1_wr_reg;
        end
    end

    sfdt_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .dry        (dry_left),
        .s0_rd_addr (rd0),
        .s1_ctl     (s1_ctl_reg),
        .s1_rd_addr (s1_rd_reg),
        .s2_ctl     (s2_ctl_reg),
        .s2_wr_addr (s2_wr_reg),
        .gain       (gain_reg),
        .sample     (lane_left)
    );

    sfdt_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .dry        (dry_right),
        .s0_rd_addr (rd0),
        .s1_ctl     (s1_ctl_reg),
        .s1_rd_addr (s1_rd_reg),
        .s2_ctl     (s2_ctl_reg),
        .s2_wr_addr (s2_wr_reg),
        .gain       (gain_reg),
        .sample     (lane_right)
    );

    // Merge both lanes into the output word; a silent voice gives zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s2_ctl_reg.vld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_ctl_reg.vld)
        begin
            out_left_reg  <= s2_ctl_reg.act ? lane_left : '0;
            out_right_reg <= s2_ctl_reg.act ? lane_right : '0;
            voice_reg     <= s2_ctl_reg.act;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign voice_active = voice_reg;

    // A word that writes the delay memory always belongs to a sounding voice.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_ctl_reg.vld && s2_ctl_reg.we) |-> s2_ctl_reg.act)
        else $error("delay write from a silent voice");

    // A voice that has gone quiet leaves its tail counter at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !voice_on_reg |-> (tail_reg == '0))
        else $error("tail counter left running with the voice off");

    // The write pointer moves only after an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg != $past(wp_reg)) |-> $past(in_acc))
        else $error("write pointer moved without an accepted word");

endmodule
